// ----- rtl/php_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package php_pkg;

    // Default identifier length in bytes (transport id and destination hash)
    localparam int HASH_ID_BYTES_DEF = 16;

    // Position counter width and its saturation value
    localparam int               POS_W   = 6;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Flags byte fields
    localparam logic [7:0] FLAG_HDR_MASK   = 8'b0100_0000;
    localparam logic [7:0] FLAG_CTX_MASK   = 8'b0010_0000;
    localparam logic [7:0] FLAG_RELAY_MASK = 8'b0001_0000;
    localparam logic [7:0] FLAG_DEST_MASK  = 8'b0000_1100;
    localparam logic [7:0] FLAG_PKT_MASK   = 8'b0000_0011;
    localparam logic [7:0] FLAG_HASH_MASK  = 8'b0000_1111;

    // Field kind of one byte
    typedef enum logic [2:0] {
        KIND_FLAGS     = 3'd0,
        KIND_HOPS      = 3'd1,
        KIND_TRANSPORT = 3'd2,
        KIND_DEST      = 3'd3,
        KIND_CONTEXT   = 3'd4,
        KIND_PAYLOAD   = 3'd5
    } t_byte_kind;

    // One accepted input item
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       last_byte;
    } t_in_item;

    // One result item
    typedef struct packed {
        t_byte_kind byte_kind;
        logic [7:0] byte_value;
        logic       hash_include;
        logic [7:0] hash_byte;
        logic       header_kind;
        logic       context_bit;
        logic       relay_kind;
        logic [1:0] target_kind;
        logic [1:0] kind_of_packet;
        logic       end_of_frame;
        logic       frame_valid;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/php_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte channel into the parser
interface php_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       last_byte;

    modport source (output valid, output raw_byte, output last_byte, input ready);
    modport sink   (input valid, input raw_byte, input last_byte, output ready);
endinterface

// Classified byte channel out of the parser
interface php_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_kind;
    logic [7:0] byte_value;
    logic       hash_include;
    logic [7:0] hash_byte;
    logic       header_kind;
    logic       context_bit;
    logic       relay_kind;
    logic [1:0] target_kind;
    logic [1:0] kind_of_packet;
    logic       end_of_frame;
    logic       frame_valid;

    modport source (
        output valid, output byte_kind, output byte_value, output hash_include,
        output hash_byte, output header_kind, output context_bit, output relay_kind,
        output target_kind, output kind_of_packet, output end_of_frame,
        output frame_valid, input ready
    );
    modport sink (
        input valid, input byte_kind, input byte_value, input hash_include,
        input hash_byte, input header_kind, input context_bit, input relay_kind,
        input target_kind, input kind_of_packet, input end_of_frame,
        input frame_valid, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/packet_header_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Packet header parser.
// i_in carries a received frame one byte per transfer, last_byte set on its
// final byte. o_out carries one classified result per input byte, in order:
// the field kind, the byte itself, its hash-input form, the decoded flags of
// the frame, and on the last byte whether the frame met its minimum length.
// HASH_ID_BYTES sets the length of the transport id and destination hash.
// A transferred byte is classified from the input register and its result
// is offered on o_out from the result register, so two register stages
// (input register, result register) lie between the channels.
// Throughput: one byte per cycle unless o_out stalls; the single position
// counter advances on each byte moving on to the result register.
// Reset (synchronous, active low) empties both registers and returns the
// position counter and held flags to the start of a frame.
// When the receiver stalls, the result holds on o_out, one more byte waits in
// the input register, and i_in.ready then drops until the result transfers.
module packet_header_parser #(
    parameter int HASH_ID_BYTES = php_pkg::HASH_ID_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    php_in_if.sink    i_in,
    php_out_if.source o_out
);

    logic              w_in_valid;
    php_pkg::t_in_item w_in_item;
    logic              w_slot_free;
    php_pkg::t_result  w_result;

    // Input register
    php_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_slot_free (w_slot_free),
        .o_valid     (w_in_valid),
        .o_item      (w_in_item)
    );

    // Classify against position and flags state
    php_decode #(
        .HASH_ID_BYTES (HASH_ID_BYTES)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_slot_free),
        .o_result  (w_result)
    );

    // Result register
    php_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_result    (w_result),
        .o_slot_free (w_slot_free),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/php_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module php_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    php_in_if.sink                 i_in,
    input  wire logic              i_slot_free,
    output logic                   o_valid,
    output php_pkg::t_in_item      o_item
);

    logic              r_valid;
    logic              n_valid;
    php_pkg::t_in_item r_item;
    logic              w_take;

    // Accept a new byte whenever the held one leaves this cycle or none is held
    assign i_in.ready = !r_valid || i_slot_free;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_slot_free) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture the payload on each transfer
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.raw_byte  <= i_in.raw_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- rtl/php_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module php_decode #(
    parameter int HASH_ID_BYTES = php_pkg::HASH_ID_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire php_pkg::t_in_item i_item,
    input  wire logic              i_advance,
    output php_pkg::t_result       o_result
);

    localparam int CW = php_pkg::POS_W + 1;

    // Field boundaries, as positions in the frame, and minimum frame lengths
    localparam logic [CW-1:0] TID_END   = CW'(2 + HASH_ID_BYTES);
    localparam logic [CW-1:0] DST0_END  = CW'(2 + HASH_ID_BYTES);
    localparam logic [CW-1:0] DST1_END  = CW'(2 + 2 * HASH_ID_BYTES);
    localparam logic [CW-1:0] MIN_LEN0  = CW'(3 + HASH_ID_BYTES);
    localparam logic [CW-1:0] MIN_LEN1  = CW'(3 + 2 * HASH_ID_BYTES);

    logic [php_pkg::POS_W-1:0] r_pos;
    logic [php_pkg::POS_W-1:0] n_pos;
    logic [7:0]                r_flags;
    logic [7:0]                n_flags;

    logic [CW-1:0]       w_pos;
    logic [CW-1:0]       w_dst_end;
    logic [7:0]          w_flags;
    logic                w_hdr2;
    logic                w_first;
    php_pkg::t_byte_kind w_kind;
    logic                w_incl;

    assign w_pos     = {1'b0, r_pos};
    assign w_first   = (r_pos == '0);
    assign w_flags   = w_first ? i_item.raw_byte : r_flags;
    assign w_hdr2    = |(w_flags & php_pkg::FLAG_HDR_MASK);
    assign w_dst_end = w_hdr2 ? DST1_END : DST0_END;

    // Classify the byte by its position and header type
    always_comb begin
        if (w_first) begin
            w_kind = php_pkg::KIND_FLAGS;
        end else if (w_pos == CW'(1)) begin
            w_kind = php_pkg::KIND_HOPS;
        end else if (w_hdr2 && (w_pos < TID_END)) begin
            w_kind = php_pkg::KIND_TRANSPORT;
        end else if (w_pos < w_dst_end) begin
            w_kind = php_pkg::KIND_DEST;
        end else if (w_pos == w_dst_end) begin
            w_kind = php_pkg::KIND_CONTEXT;
        end else begin
            w_kind = php_pkg::KIND_PAYLOAD;
        end
    end

    assign w_incl = !((w_kind == php_pkg::KIND_HOPS) || (w_kind == php_pkg::KIND_TRANSPORT));

    // Build the result fields
    always_comb begin
        o_result.byte_kind      = w_kind;
        o_result.byte_value     = i_item.raw_byte;
        o_result.hash_include   = w_incl;
        if (!w_incl) begin
            o_result.hash_byte = 8'h00;
        end else if (w_first) begin
            o_result.hash_byte = i_item.raw_byte & php_pkg::FLAG_HASH_MASK;
        end else begin
            o_result.hash_byte = i_item.raw_byte;
        end
        o_result.header_kind    = w_hdr2;
        o_result.context_bit    = |(w_flags & php_pkg::FLAG_CTX_MASK);
        o_result.relay_kind     = |(w_flags & php_pkg::FLAG_RELAY_MASK);
        o_result.target_kind    = w_flags[3:2];
        o_result.kind_of_packet = w_flags[1:0];
        o_result.end_of_frame   = i_item.last_byte;
        o_result.frame_valid    = i_item.last_byte &&
                                  ((w_pos + CW'(1)) >= (w_hdr2 ? MIN_LEN1 : MIN_LEN0));
    end

    // Advance position and flags; clear both at the end of a frame
    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        if (i_valid && i_advance) begin
            if (i_item.last_byte) begin
                n_pos   = '0;
                n_flags = 8'h00;
            end else begin
                if (w_first) begin
                    n_flags = i_item.raw_byte;
                end
                if (r_pos != php_pkg::POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= 8'h00;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/php_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module php_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire php_pkg::t_result i_result,
    output logic                  o_slot_free,
    php_out_if.source             o_out
);

    logic             r_valid;
    logic             n_valid;
    php_pkg::t_result r_result;
    logic             w_load;

    // The register frees up when empty or when its result transfers
    assign o_slot_free = !r_valid || o_out.ready;
    assign w_load      = i_valid && o_slot_free;

    always_comb begin
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the result until it transfers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.byte_kind      = r_result.byte_kind;
    assign o_out.byte_value     = r_result.byte_value;
    assign o_out.hash_include   = r_result.hash_include;
    assign o_out.hash_byte      = r_result.hash_byte;
    assign o_out.header_kind    = r_result.header_kind;
    assign o_out.context_bit    = r_result.context_bit;
    assign o_out.relay_kind     = r_result.relay_kind;
    assign o_out.target_kind    = r_result.target_kind;
    assign o_out.kind_of_packet = r_result.kind_of_packet;
    assign o_out.end_of_frame   = r_result.end_of_frame;
    assign o_out.frame_valid    = r_result.frame_valid;

endmodule

`default_nettype wire

// ----- rtl/php_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module php_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_byte_kind,
    input wire logic [7:0] i_byte_value,
    input wire logic       i_hash_include,
    input wire logic [7:0] i_hash_byte,
    input wire logic       i_end_of_frame,
    input wire logic       i_frame_valid
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A stalled result stays offered
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result withdrawn");

    // Frame validity is only reported on the last byte
    a_valid_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_valid |-> i_end_of_frame)
        else $error("frame_valid set off the last byte");

    // Excluded bytes give a zero hash byte
    a_excl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hash_include |-> (i_hash_byte == 8'h00))
        else $error("hash byte nonzero on an excluded byte");

    // The flags byte is hashed as its low nibble
    a_flags_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_byte_kind == php_pkg::KIND_FLAGS) |->
            i_hash_include && (i_hash_byte == (i_byte_value & php_pkg::FLAG_HASH_MASK)))
        else $error("flags byte hash form wrong");

endmodule

bind packet_header_parser php_checker u_php_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_byte_kind    (o_out.byte_kind),
    .i_byte_value   (o_out.byte_value),
    .i_hash_include (o_out.hash_include),
    .i_hash_byte    (o_out.hash_byte),
    .i_end_of_frame (o_out.end_of_frame),
    .i_frame_valid  (o_out.frame_valid)
);

`default_nettype wire

// ----- verif/parse_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the header parser, predicts the classification of
// every byte that enters and compares each result that leaves, in order.
module parse_checker
    import php_pkg::*;
#(
    parameter int HASH_ID_BYTES = HASH_ID_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    php_in_if         i_byte_ch,
    php_out_if        i_result_ch,
    output int        o_mismatches,
    output int        o_pending
);

    // Frame tracking state of the prediction
    logic [POS_W-1:0] frame_pos;
    logic [7:0]       frame_flags;

    t_result results_due[$];
    t_result seen_result;
    t_result due_result;
    int      mismatch_count;

    assign o_mismatches = mismatch_count;

    // Classify one byte of the current frame and advance the frame state
    function automatic t_result classify_byte(input logic [7:0] b, input logic is_last);
        t_result    r;
        logic [7:0] f;
        logic       relayed;
        int         p;
        int         ctx_pos;
        int         min_len;
        p       = int'(frame_pos);
        f       = (p == 0) ? b : frame_flags;
        relayed = |(f & FLAG_HDR_MASK);
        ctx_pos = relayed ? 2 + 2 * HASH_ID_BYTES : 2 + HASH_ID_BYTES;
        min_len = ctx_pos + 1;

        if (p == 0) begin
            r.byte_kind = KIND_FLAGS;
        end else if (p == 1) begin
            r.byte_kind = KIND_HOPS;
        end else if (relayed && p < 2 + HASH_ID_BYTES) begin
            r.byte_kind = KIND_TRANSPORT;
        end else if (p < ctx_pos) begin
            r.byte_kind = KIND_DEST;
        end else if (p == ctx_pos) begin
            r.byte_kind = KIND_CONTEXT;
        end else begin
            r.byte_kind = KIND_PAYLOAD;
        end

        // Hop count and transport id stay out of the hashed part
        r.byte_value   = b;
        r.hash_include = !(r.byte_kind == KIND_HOPS || r.byte_kind == KIND_TRANSPORT);
        if (!r.hash_include) begin
            r.hash_byte = 8'h00;
        end else if (r.byte_kind == KIND_FLAGS) begin
            r.hash_byte = b & FLAG_HASH_MASK;
        end else begin
            r.hash_byte = b;
        end

        r.header_kind    = relayed;
        r.context_bit    = |(f & FLAG_CTX_MASK);
        r.relay_kind     = |(f & FLAG_RELAY_MASK);
        r.target_kind    = 2'((f & FLAG_DEST_MASK) >> 2);
        r.kind_of_packet = 2'(f & FLAG_PKT_MASK);
        r.end_of_frame   = is_last;
        r.frame_valid    = is_last && (p + 1 >= min_len);

        // Restart on the last byte, otherwise hold flags and saturate position
        if (is_last) begin
            frame_pos   = '0;
            frame_flags = 8'h00;
        end else begin
            if (p == 0) frame_flags = b;
            if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    initial mismatch_count = 0;

    // Queue a prediction per input transfer, retire one per result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos   = '0;
            frame_flags = 8'h00;
            results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                results_due.push_back(classify_byte(i_byte_ch.raw_byte, i_byte_ch.last_byte));
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                seen_result.byte_kind      = t_byte_kind'(i_result_ch.byte_kind);
                seen_result.byte_value     = i_result_ch.byte_value;
                seen_result.hash_include   = i_result_ch.hash_include;
                seen_result.hash_byte      = i_result_ch.hash_byte;
                seen_result.header_kind    = i_result_ch.header_kind;
                seen_result.context_bit    = i_result_ch.context_bit;
                seen_result.relay_kind     = i_result_ch.relay_kind;
                seen_result.target_kind    = i_result_ch.target_kind;
                seen_result.kind_of_packet = i_result_ch.kind_of_packet;
                seen_result.end_of_frame   = i_result_ch.end_of_frame;
                seen_result.frame_valid    = i_result_ch.frame_valid;
                if (results_due.size() == 0) begin
                    $error("result with no byte waiting: byte_value 0x%0h",
                           seen_result.byte_value);
                    mismatch_count++;
                end else begin
                    due_result = results_due.pop_front();
                    check_field("byte_kind", 8'(due_result.byte_kind),
                                8'(seen_result.byte_kind));
                    check_field("byte_value", due_result.byte_value, seen_result.byte_value);
                    check_field("hash_include", 8'(due_result.hash_include),
                                8'(seen_result.hash_include));
                    check_field("hash_byte", due_result.hash_byte, seen_result.hash_byte);
                    check_field("header_kind", 8'(due_result.header_kind),
                                8'(seen_result.header_kind));
                    check_field("context_bit", 8'(due_result.context_bit),
                                8'(seen_result.context_bit));
                    check_field("relay_kind", 8'(due_result.relay_kind),
                                8'(seen_result.relay_kind));
                    check_field("target_kind", 8'(due_result.target_kind),
                                8'(seen_result.target_kind));
                    check_field("kind_of_packet", 8'(due_result.kind_of_packet),
                                8'(seen_result.kind_of_packet));
                    check_field("end_of_frame", 8'(due_result.end_of_frame),
                                8'(seen_result.end_of_frame));
                    check_field("frame_valid", 8'(due_result.frame_valid),
                                8'(seen_result.frame_valid));
                end
            end
            o_pending <= results_due.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import php_pkg::*;

    localparam int ID_BYTES    = HASH_ID_BYTES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BYTES = 125;

    logic i_clk = 1'b0;
    logic i_rst_n;

    php_in_if  byte_ch ();
    php_out_if result_ch ();

    int mismatches;
    int results_pending;

    int send_idle_pct;
    int stall_pct;
    int idle_cycles;

    int frames_sent;
    int bytes_sent;
    int short_frames;
    int saturated_frames;

    // Idle and stall percentages per phase: none, sender, receiver, both
    int phase_send_idle[4] = '{0, 67, 0, 9};
    int phase_stall[4]     = '{0, 0, 67, 9};

    packet_header_parser #(
        .HASH_ID_BYTES(ID_BYTES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (result_ch)
    );

    parse_checker #(
        .HASH_ID_BYTES(ID_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .i_result_ch (result_ch),
        .o_mismatches(mismatches),
        .o_pending   (results_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Randomly stall the result channel
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n ||
            (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one byte, with random idle cycles first, until it transfers
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.raw_byte  <= b;
        byte_ch.last_byte <= is_last;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (results_pending != 0);
    endtask

    task automatic send_frame(input logic [7:0] flags, input int len, input bit alt_fill);
        logic [7:0] b;
        int         min_len;
        min_len = flags[6] ? 3 + 2 * ID_BYTES : 3 + ID_BYTES;
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                b = flags;
            end else if (alt_fill) begin
                b = (i % 2 == 1) ? 8'hFF : 8'h00;
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, i == len - 1);
        end
        frames_sent++;
        if (len < min_len) short_frames++;
        if (len > 64) saturated_frames++;
    endtask

    // Mostly lengths near the minimum, some short, a few past saturation
    task automatic send_random_frame();
        logic [7:0] flags;
        int         min_len;
        int         len;
        int         pick;
        flags   = 8'($urandom);
        min_len = flags[6] ? 3 + 2 * ID_BYTES : 3 + ID_BYTES;
        pick    = $urandom_range(99);
        if (pick < 35) begin
            len = min_len - 1 + $urandom_range(2);
        end else if (pick < 55) begin
            len = $urandom_range(min_len + 12, min_len + 2);
        end else if (pick < 72) begin
            len = $urandom_range(6, 1);
        end else if (pick < 90) begin
            len = $urandom_range(min_len - 2, 2);
        end else begin
            len = $urandom_range(72, 62);
        end
        send_frame(flags, len, 1'b0);
        if ($urandom_range(99) < 4) wait_drained();
    endtask

    initial begin
        int phase_start;

        i_rst_n             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.raw_byte    = 8'h00;
        byte_ch.last_byte   = 1'b0;
        result_ch.ready     = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        idle_cycles         = 0;
        frames_sent         = 0;
        bytes_sent          = 0;
        short_frames        = 0;
        saturated_frames    = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: one-byte frames, a hop-count-only frame, a minimum plain frame
        send_frame(8'hFF, 1, 1'b1);
        send_frame(8'h00, 1, 1'b1);
        send_frame(8'h40, 2, 1'b1);
        send_frame(8'hBF, 3 + ID_BYTES, 1'b1);
        wait_drained();

        // Random frames under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_send_idle[ph];
            stall_pct     = phase_stall[ph];
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
            wait_drained();
        end

        // Let any stray result show up
        stall_pct = 0;
        repeat (10) @(posedge i_clk);

        $display("Sent %0d frames, %0d bytes: %0d below minimum length, %0d past saturation",
                 frames_sent, bytes_sent, short_frames, saturated_frames);
        $display("Idling phases: none, sender 67%%, receiver 67%%, both 9%%");
        if (mismatches == 0 && results_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/php_pkg.sv
rtl/php_if.sv
rtl/php_in_reg.sv
rtl/php_decode.sv
rtl/php_out_reg.sv
rtl/packet_header_parser.sv
rtl/php_checker.sv
verif/parse_checker.sv
verif/testbench.sv
